[rtl/core/lou_pkg.sv]
// ----------------------------------------------------------------------------
// lou_pkg: shared types and constants of the level-ordered unique list
// Sizes, operation codes, the transaction payloads and the cell control and
// flag structs used between the cell row and the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lou_pkg;

	localparam int DEPTH      = 16;
	localparam int ID_BITS    = 16;
	localparam int LEVEL_BITS = 8;
	localparam int FUNC_BITS  = 3;
	localparam int CNT_BITS   = $clog2(DEPTH + 1);

	localparam logic [FUNC_BITS-1:0] FUNC_APPEND   = 3'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_INSERT   = 3'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_REMOVE   = 3'd2;
	localparam logic [FUNC_BITS-1:0] FUNC_CONTAINS = 3'd3;
	localparam logic [FUNC_BITS-1:0] FUNC_CLEAR    = 3'd4;

	typedef logic [DEPTH-1:0]      vec_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;
	typedef logic [ID_BITS-1:0]    id_t;
	typedef logic [LEVEL_BITS-1:0] level_t;

	typedef struct packed {
		logic [FUNC_BITS-1:0] func;
		id_t                  entry_id;
		level_t               entry_level;
	} req_t;

	typedef struct packed {
		logic hit;
		logic dropped;
		cnt_t entry_count;
		logic is_empty;
	} rsp_t;

	// per-cell update command; at most one bit is set
	typedef struct packed {
		logic load;
		logic from_prev;
		logic from_next;
	} cell_cmd_t;

	// per-cell compare results against the request
	typedef struct packed {
		logic id_eq;
		logic level_le;
	} cell_flag_t;

	// ones in bits 0..i
	function automatic vec_t mask_upto(input int unsigned i);
		return (vec_t'(1) << (i + 1)) - vec_t'(1);
	endfunction

endpackage

`default_nettype wire

[rtl/core/lou_cell.sv]
// ----------------------------------------------------------------------------
// lou_cell: one slot of the list
// Holds an identifier and a level, compares them with the request and takes
// the request or a neighbor's contents when the controller says so.
// ----------------------------------------------------------------------------
`default_nettype none

module lou_cell (
	input  wire logic               clk,
	input  wire lou_pkg::cell_cmd_t cmd,
	input  wire lou_pkg::id_t       new_id,
	input  wire lou_pkg::level_t    new_level,
	input  wire lou_pkg::id_t       prev_id,
	input  wire lou_pkg::level_t    prev_level,
	input  wire lou_pkg::id_t       next_id,
	input  wire lou_pkg::level_t    next_level,
	output lou_pkg::id_t            id,
	output lou_pkg::level_t         level,
	output lou_pkg::cell_flag_t     flag
);

	lou_pkg::id_t    id_q;
	lou_pkg::level_t level_q;

	always_ff @(posedge clk) begin
		unique if (cmd.load) begin
			id_q    <= new_id;
			level_q <= new_level;
		end else if (cmd.from_prev) begin
			id_q    <= prev_id;
			level_q <= prev_level;
		end else if (cmd.from_next) begin
			id_q    <= next_id;
			level_q <= next_level;
		end else begin
			// hold
			id_q    <= id_q;
			level_q <= level_q;
		end
	end

	assign id             = id_q;
	assign level          = level_q;
	assign flag.id_eq     = (id_q == new_id);
	assign flag.level_le  = (level_q <= new_level);

endmodule

`default_nettype wire

[rtl/core/lou_ctrl.sv]
// ----------------------------------------------------------------------------
// lou_ctrl: list controller
// Keeps the fill count, finds the insert point, duplicates and the first match
// from the cell flags, and drives every cell's command for one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module lou_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire lou_pkg::req_t       req,
	input  wire lou_pkg::cell_flag_t flags [lou_pkg::DEPTH],
	output lou_pkg::cell_cmd_t       cmds  [lou_pkg::DEPTH],
	output lou_pkg::rsp_t            rsp
);

	lou_pkg::cnt_t count_q;
	lou_pkg::cnt_t count_nxt;
	lou_pkg::vec_t ok;       // occupied and level at most the new level
	lou_pkg::vec_t match;    // occupied and same identifier
	lou_pkg::vec_t in_pfx;   // all cells up to here are in the insert prefix
	lou_pkg::vec_t prev_pfx; // in_pfx of the cell before
	lou_pkg::vec_t after_m;  // at or after the first match
	lou_pkg::vec_t loads;
	logic          full;
	logic          dup;
	logic          found;
	logic          hit;
	logic          dropped;

	always_comb begin
		for (int i = 0; i < lou_pkg::DEPTH; i++) begin
			ok[i]    = (lou_pkg::cnt_t'(i) < count_q) && flags[i].level_le;
			match[i] = (lou_pkg::cnt_t'(i) < count_q) && flags[i].id_eq;
		end
		for (int i = 0; i < lou_pkg::DEPTH; i++) begin
			in_pfx[i]  = &(ok | ~lou_pkg::mask_upto(i));
			after_m[i] = |(match & lou_pkg::mask_upto(i));
		end
	end

	assign prev_pfx = {in_pfx[lou_pkg::DEPTH-2:0], 1'b1};
	assign full     = (count_q == lou_pkg::cnt_t'(lou_pkg::DEPTH));
	assign dup      = |(in_pfx & match);
	assign found    = |match;

	always_comb begin
		count_nxt = count_q;
		hit       = 1'b0;
		dropped   = 1'b0;
		for (int i = 0; i < lou_pkg::DEPTH; i++) begin
			cmds[i] = '0;
		end
		unique case (req.func)
			lou_pkg::FUNC_APPEND: begin
				if (full) begin
					dropped = 1'b1;
				end else begin
					count_nxt = count_q + lou_pkg::cnt_t'(1);
					for (int i = 0; i < lou_pkg::DEPTH; i++) begin
						cmds[i].load = fire && (lou_pkg::cnt_t'(i) == count_q);
					end
				end
			end
			lou_pkg::FUNC_INSERT: begin
				if (dup) begin
					hit = 1'b1;
				end else if (full) begin
					dropped = 1'b1;
				end else begin
					count_nxt = count_q + lou_pkg::cnt_t'(1);
					// keep the prefix, load at its end, move the rest up by one
					for (int i = 0; i < lou_pkg::DEPTH; i++) begin
						cmds[i].load      = fire && !in_pfx[i] && prev_pfx[i];
						cmds[i].from_prev = fire && !prev_pfx[i];
					end
				end
			end
			lou_pkg::FUNC_REMOVE: begin
				if (found) begin
					hit       = 1'b1;
					count_nxt = count_q - lou_pkg::cnt_t'(1);
					// close the gap from the first match onward
					for (int i = 0; i < lou_pkg::DEPTH - 1; i++) begin
						cmds[i].from_next = fire && after_m[i];
					end
				end
			end
			lou_pkg::FUNC_CONTAINS: begin
				hit = found;
			end
			lou_pkg::FUNC_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_nxt;
		end
	end

	always_comb begin
		for (int i = 0; i < lou_pkg::DEPTH; i++) begin
			loads[i] = cmds[i].load;
		end
	end

	assign rsp.hit         = hit;
	assign rsp.dropped     = dropped;
	assign rsp.entry_count = count_nxt;
	assign rsp.is_empty    = (count_nxt == '0);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lou_pkg::cnt_t'(lou_pkg::DEPTH))
		else $error("fill count above depth");

	a_single_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(loads))
		else $error("more than one cell loads the request");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.func == lou_pkg::FUNC_CLEAR |=> count_q == '0)
		else $error("clear left entries");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.func == lou_pkg::FUNC_APPEND && !full
		|=> count_q == $past(count_q) + lou_pkg::cnt_t'(1))
		else $error("append did not grow the list");

endmodule

`default_nettype wire

[rtl/core/level_ordered_unique_list.sv]
// A result is registered and valid in the cycle after its request is accepted.
// One request per cycle while req_stall is low; the whole row of cells updates in the
// cycle of acceptance, so the next request may follow at once.
// Request stall is raised only while a result waits and the output stalls.
// Reset clears the fill count and the result valid flag; cell contents are
// not reset and are never read before they are written.
// ----------------------------------------------------------------------------
// level_ordered_unique_list: bounded level-ordered list with unique insert
// A row of slot cells with neighbor shifting, a controller that decodes each
// request, and a registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module level_ordered_unique_list (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire lou_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output lou_pkg::rsp_t      rsp
);

	lou_pkg::cell_flag_t flags  [lou_pkg::DEPTH];
	lou_pkg::cell_cmd_t  cmds   [lou_pkg::DEPTH];
	lou_pkg::id_t        ids    [lou_pkg::DEPTH];
	lou_pkg::level_t     levels [lou_pkg::DEPTH];
	lou_pkg::rsp_t       rsp_nxt;
	lou_pkg::rsp_t       rsp_q;
	logic                rsp_valid_q;
	logic                fire;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign fire      = req_valid && !req_stall;

	lou_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req),
		.flags  (flags),
		.cmds   (cmds),
		.rsp    (rsp_nxt)
	);

	for (genvar g = 0; g < lou_pkg::DEPTH; g++) begin : g_cell
		lou_pkg::id_t    prev_id;
		lou_pkg::level_t prev_level;
		lou_pkg::id_t    next_id;
		lou_pkg::level_t next_level;

		if (g == 0) begin : g_first
			assign prev_id    = '0;
			assign prev_level = '0;
		end else begin : g_mid_prev
			assign prev_id    = ids[g-1];
			assign prev_level = levels[g-1];
		end

		if (g == lou_pkg::DEPTH - 1) begin : g_last
			assign next_id    = '0;
			assign next_level = '0;
		end else begin : g_mid_next
			assign next_id    = ids[g+1];
			assign next_level = levels[g+1];
		end

		lou_cell u_cell (
			.clk        (clk),
			.cmd        (cmds[g]),
			.new_id     (req.entry_id),
			.new_level  (req.entry_level),
			.prev_id    (prev_id),
			.prev_level (prev_level),
			.next_id    (next_id),
			.next_level (next_level),
			.id         (ids[g]),
			.level      (levels[g]),
			.flag       (flags[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.is_empty == (rsp_q.entry_count == '0))
		else $error("empty flag disagrees with count");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_q.hit && rsp_q.dropped))
		else $error("hit and dropped both set");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q)
		else $error("accepted request produced no result");

endmodule

`default_nettype wire
